FILE: sv/hw_monitor_reading_convert_defines.svh
// assertion macros for the reading converter
`ifndef HW_MONITOR_READING_CONVERT_DEFINES_SVH
`define HW_MONITOR_READING_CONVERT_DEFINES_SVH

`ifndef SYNTHESIS
`define HMRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HMRC_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define HMRC_ASSERT(lbl, prop, msg)
`define HMRC_NEVER(lbl, expr, msg)
`endif

`endif

FILE: sv/hmrc_pkg.sv
package hmrc_pkg;

	localparam int CLK_W = 24;
	localparam int CNT_W = 8;
	localparam int READ_W = 16;
	localparam int EXP_W = 3;

	localparam logic [CLK_W-1:0] FAN_CLK_RESET = 24'd1350000;
	localparam logic [READ_W-1:0] SAT16 = 16'hFFFF;
	localparam logic [CNT_W-1:0] CNT_FULL = 8'hFF;

	localparam logic [3:0] VOLT_CHANNELS = 4'd9;
	localparam logic [3:0] TEMP_CHANNELS = 4'd3;
	localparam logic [3:0] FAN_CHANNELS = 4'd3;

	localparam logic [1:0] FUNC_VOLT = 2'd0;
	localparam logic [1:0] FUNC_TEMP = 2'd1;
	localparam logic [1:0] FUNC_FAN = 2'd2;

	localparam logic [3:0] CH_FAN0 = 4'd0;
	localparam logic [3:0] CH_FAN1 = 4'd1;
	localparam logic [3:0] CH_TEMP0 = 4'd0;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] channel;
		logic [7:0] raw_value;
		logic [7:0] low_byte;
		logic [7:0] divisor_high;
	} in_t;

	typedef struct packed {
		logic [READ_W-1:0] reading;
		logic status;
	} out_t;

	typedef struct packed {
		logic is_fan;
		out_t res;
	} tag_t;

	typedef struct packed {
		tag_t tag;
		logic [CLK_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} front_t;

	typedef struct packed {
		logic [CNT_W-1:0] rem;
		logic [CLK_W-1:0] num;
	} div_t;

endpackage

FILE: sv/hmrc_dec.sv
module hmrc_dec (
	input hmrc_pkg::in_t item,
	input logic [hmrc_pkg::CLK_W-1:0] fan_count_clock,
	output hmrc_pkg::front_t front
);
	import hmrc_pkg::*;

	logic [EXP_W-1:0] fan_exp;
	logic half;
	logic [8:0] temp9;
	logic cnt_zero;
	logic cnt_full;

	always_comb begin
		unique case (item.channel)
			CH_FAN0: fan_exp = {item.divisor_high[5], item.low_byte[5:4]};
			CH_FAN1: fan_exp = {item.divisor_high[6], item.low_byte[7:6]};
			default: fan_exp = {item.divisor_high[7], item.low_byte[7:6]};
		endcase
	end

	assign half = (item.channel == CH_TEMP0) ? 1'b0 : item.low_byte[7];
	assign temp9 = {item.raw_value, half};
	assign cnt_zero = (item.raw_value == '0);
	assign cnt_full = (item.raw_value == CNT_FULL);

	always_comb begin
		front.tag.is_fan = 1'b0;
		front.tag.res.reading = '0;
		front.tag.res.status = 1'b1;
		front.dividend = fan_count_clock >> fan_exp;
		front.divisor = item.raw_value;
		unique case (item.func)
			FUNC_VOLT: begin
				if (item.channel < VOLT_CHANNELS) begin
					front.tag.res.reading = {{(READ_W-CNT_W){1'b0}}, item.raw_value};
					front.tag.res.status = 1'b0;
				end
			end
			FUNC_TEMP: begin
				if (item.channel < TEMP_CHANNELS) begin
					front.tag.res.reading = {{(READ_W-9){temp9[8]}}, temp9};
					front.tag.res.status = 1'b0;
				end
			end
			FUNC_FAN: begin
				if (item.channel < FAN_CHANNELS) begin
					front.tag.res.status = 1'b0;
					if (cnt_full) begin
						front.tag.res.reading = SAT16;
					end else if (!cnt_zero) begin
						front.tag.is_fan = 1'b1;
					end
				end
			end
			default: begin
				front.tag.res.status = 1'b1;
			end
		endcase
	end

endmodule

FILE: sv/hw_monitor_reading_convert.sv
// done and result are registered; a started beat passes the decode, divider and output registers in turn
// throughput: one beat per cycle, busy never asserts
// the pipeline is a decode stage, four divider stages of 6 quotient bits each and the output register
// async reset clears all valid bits and loads fan_count_clock with 1350000
// the receiver cannot stall; results are never held back
`include "hw_monitor_reading_convert_defines.svh"

module hw_monitor_reading_convert (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input hmrc_pkg::in_t item,
	input logic cfg_we,
	input logic [hmrc_pkg::CLK_W-1:0] cfg_wdata,
	output logic done,
	output hmrc_pkg::out_t result
);
	import hmrc_pkg::*;

	localparam int STEP_BITS = 6;

	function automatic div_t div_bits(input div_t d, input logic [CNT_W-1:0] den);
		div_t r;
		logic [CNT_W:0] t;
		logic ge;
		r = d;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r.rem, r.num[CLK_W-1]};
			ge = (t >= {1'b0, den});
			r.num = {r.num[CLK_W-2:0], ge};
			r.rem = ge ? CNT_W'(t - {1'b0, den}) : t[CNT_W-1:0];
		end
		return r;
	endfunction

	logic [CLK_W-1:0] fan_clk_q;
	front_t front;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	div_t div_s1, div_s2, div_s3, div_s4, div_s5;
	logic [CNT_W-1:0] den_s1, den_s2, den_s3, den_s4;
	logic done_q;
	out_t res_q;
	out_t res_next;

	assign busy = 1'b0;

	hmrc_dec u_dec (
		.item(item),
		.fan_count_clock(fan_clk_q),
		.front(front)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fan_clk_q <= FAN_CLK_RESET;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				fan_clk_q <= cfg_wdata;
			end
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			done_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= front.tag;
		div_s1 <= '{rem: '0, num: front.dividend};
		den_s1 <= front.divisor;

		tag_s2 <= tag_s1;
		div_s2 <= div_bits(div_s1, den_s1);
		den_s2 <= den_s1;

		tag_s3 <= tag_s2;
		div_s3 <= div_bits(div_s2, den_s2);
		den_s3 <= den_s2;

		tag_s4 <= tag_s3;
		div_s4 <= div_bits(div_s3, den_s3);
		den_s4 <= den_s3;

		tag_s5 <= tag_s4;
		div_s5 <= div_bits(div_s4, den_s4);

		res_q <= res_next;
	end

	always_comb begin
		res_next = tag_s5.res;
		if (tag_s5.is_fan) begin
			res_next.status = 1'b0;
			res_next.reading = (|div_s5.num[CLK_W-1:READ_W]) ? SAT16
				: div_s5.num[READ_W-1:0];
		end
	end

	assign done = done_q;
	assign result = res_q;

	`HMRC_ASSERT(a_latency, start && !busy |-> ##6 done, "accepted beat did not complete")
	`HMRC_ASSERT(a_no_orphan, done |-> $past(start && !busy, 6), "result without accepted beat")
	`HMRC_ASSERT(a_status_zero, done && result.status |-> result.reading == '0, "unsupported beat with nonzero reading")
	`HMRC_NEVER(a_fan_tag, v_s1 && tag_s1.is_fan && tag_s1.res.status, "fan divide on unsupported beat")

endmodule
